/* hdl/apq_pkg.sv */
// Package: shared types and constants for the aging priority queue.
package apq_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned SrcW   = 8;
  localparam int unsigned StampW = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned IvlW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW   = 16;

  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd2;
  localparam logic [StatW-1:0] ST_SHUT  = 2'd3;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_IVL  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CAP  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SLOT = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_STOP = 2'd3;

  typedef struct packed {
    logic              func;
    logic [DataW-1:0]  in_data;
    logic [PrioW-1:0]  in_priority;
    logic [SrcW-1:0]   in_source;
    logic [StampW-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [DataW-1:0]  out_data;
    logic [PrioW-1:0]  out_priority;
    logic [SrcW-1:0]   out_source;
    logic [StampW-1:0] out_stamp;
    logic [4:0]        fill_level;
  } rsp_t;

  // Divider control between sequencer and divider.
  typedef struct packed {
    logic              start;
    logic [StampW-1:0] num;
    logic [IvlW-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [StampW-1:0] quo;
  } div_rsp_t;

endpackage

/* hdl/apq_if.sv */
// Interfaces: valid/ready channels for request and result items.
interface apq_req_if;
  logic            valid;
  logic            ready;
  apq_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface apq_rsp_if;
  logic            valid;
  logic            ready;
  apq_pkg::rsp_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/aging_priority_queue.sv */
// Top level: aging priority queue with a shared serial divider for the scan.
// Enqueue, full, empty and shut down: pointers are wrapped, the request decided, the result registered.
// Dequeue: each stored message is read and, when it is aged, divided before its compare;
// the picked entry is then captured and the slots in front of it are shifted one slot back.
// A pointer at or above a reduced capacity is first brought below it by repeated subtracts.
// One item at a time; in_ready is low until the result is taken.
// rst_n (synchronous) clears pointers, occupancy and registers to defaults;
// slot storage is not cleared.
module aging_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  apq_req_if.sink                      in_ch,
  apq_rsp_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [apq_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [apq_pkg::CfgW-1:0]     cfg_data
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_DECIDE, S_READ, S_WAIT, S_DIV, S_CMP, S_PICK, S_SHIFT_RD,
    S_SHIFT_WR, S_DONE
  } state_t;

  // slot storage
  logic [apq_pkg::DataW-1:0]  mem_data  [DEPTH];
  logic [apq_pkg::PrioW-1:0]  mem_prio  [DEPTH];
  logic [apq_pkg::SrcW-1:0]   mem_src   [DEPTH];
  logic [apq_pkg::StampW-1:0] mem_stamp [DEPTH];

  // config registers
  logic [apq_pkg::IvlW-1:0]  ivl_r;
  logic [apq_pkg::PrioW-1:0] pcap_r;
  logic [4:0]                slots_r;
  logic                      stop_r;

  state_t                     state_r;
  apq_pkg::req_t              req_r;
  apq_pkg::rsp_t              rsp_r;
  logic                       ovalid_r;
  logic [AW-1:0]              head_r, tail_r;
  logic [CW-1:0]              occ_r;
  logic [CW-1:0]              cap;
  logic [CW-1:0]              idx_r;       // scan count
  logic [AW-1:0]              pos_r;       // scan slot
  logic [AW-1:0]              best_r;
  logic [apq_pkg::PrioW-1:0]  best_eff_r;
  logic [apq_pkg::StampW-1:0] best_stamp_r;
  logic [AW-1:0]              cur_r;

  // registered memory read port
  logic [AW-1:0]              raddr;
  logic [apq_pkg::DataW-1:0]  rd_data_r;
  logic [apq_pkg::PrioW-1:0]  rd_prio_r;
  logic [apq_pkg::SrcW-1:0]   rd_src_r;
  logic [apq_pkg::StampW-1:0] rd_stamp_r;

  // memory write port
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [apq_pkg::DataW-1:0]  wd_data;
  logic [apq_pkg::PrioW-1:0]  wd_prio;
  logic [apq_pkg::SrcW-1:0]   wd_src;
  logic [apq_pkg::StampW-1:0] wd_stamp;

  apq_pkg::div_req_t div_req;
  apq_pkg::div_rsp_t div_rsp;

  apq_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // effective capacity: clamp zero to one and anything above DEPTH to DEPTH
  always_comb begin
    if (slots_r == 5'd0)                 cap = CW'(1);
    else if (32'(slots_r) > DEPTH)       cap = CW'(DEPTH);
    else                                 cap = CW'(slots_r);
  end

  // wrap helpers on narrow values
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p,
                                             input logic [CW-1:0] c);
    logic [CW:0] s;
    s = {1'b0, CW'(p)} + 1'b1;
    if (s >= {1'b0, c}) s = s - {1'b0, c};
    return AW'(s);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p,
                                             input logic [CW-1:0] c);
    logic [CW:0] s;
    s = {1'b0, CW'(p)} + {1'b0, c} - 1'b1;
    if (s >= {1'b0, c}) s = s - {1'b0, c};
    return AW'(s);
  endfunction

  // aging step on the divider result
  logic [apq_pkg::StampW:0]   eff_sum;
  logic [apq_pkg::PrioW-1:0]  eff;
  logic                       aged;
  logic [apq_pkg::StampW-1:0] quo_r;

  assign aged = (req_r.now_time > rd_stamp_r) && (ivl_r != '0);

  always_comb begin
    eff_sum = {1'b0, aged ? quo_r : '0} + (apq_pkg::StampW+1)'(rd_prio_r);
    if (eff_sum > (apq_pkg::StampW+1)'(pcap_r)) eff = pcap_r;
    else                                       eff = eff_sum[apq_pkg::PrioW-1:0];
  end

  assign div_req.num   = req_r.now_time - rd_stamp_r;
  assign div_req.den   = ivl_r;
  assign div_req.start = (state_r == S_WAIT) && aged;

  // read address and write port
  always_comb begin
    raddr    = pos_r;
    we       = 1'b0;
    waddr    = tail_r;
    wd_data  = req_r.in_data;
    wd_prio  = req_r.in_priority;
    wd_src   = req_r.in_source;
    wd_stamp = req_r.now_time;
    if (state_r == S_PICK) raddr = best_r;
    if (state_r == S_SHIFT_RD) raddr = wrap_dec(cur_r, cap);
    if (state_r == S_DECIDE && !stop_r && req_r.func == apq_pkg::FUNC_ENQ &&
        occ_r < cap) begin
      we = 1'b1;
    end
    if (state_r == S_SHIFT_WR) begin
      we       = 1'b1;
      waddr    = cur_r;
      wd_data  = rd_data_r;
      wd_prio  = rd_prio_r;
      wd_src   = rd_src_r;
      wd_stamp = rd_stamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_data[waddr]  <= wd_data;
      mem_prio[waddr]  <= wd_prio;
      mem_src[waddr]   <= wd_src;
      mem_stamp[waddr] <= wd_stamp;
    end
    rd_data_r  <= mem_data[raddr];
    rd_prio_r  <= mem_prio[raddr];
    rd_src_r   <= mem_src[raddr];
    rd_stamp_r <= mem_stamp[raddr];
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = ovalid_r;
  assign out_ch.payload = rsp_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      head_r   <= '0;
      tail_r   <= '0;
      occ_r    <= '0;
      ivl_r    <= 16'd1000;
      pcap_r   <= 8'd10;
      slots_r  <= 5'd16;
      stop_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          apq_pkg::REG_IVL:  ivl_r   <= cfg_data[apq_pkg::IvlW-1:0];
          apq_pkg::REG_CAP:  pcap_r  <= cfg_data[apq_pkg::PrioW-1:0];
          apq_pkg::REG_SLOT: slots_r <= cfg_data[4:0];
          apq_pkg::REG_STOP: stop_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (div_rsp.done) quo_r <= div_rsp.quo;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            req_r   <= in_ch.payload;
            state_r <= S_WRAP;
          end
        end
        S_WRAP: begin
          // take pointers modulo the capacity, one subtract per cycle
          if (CW'(head_r) >= cap) head_r <= head_r - AW'(cap);
          if (CW'(tail_r) >= cap) tail_r <= tail_r - AW'(cap);
          if (CW'(head_r) < cap && CW'(tail_r) < cap) state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          rsp_r            <= '0;
          rsp_r.fill_level <= 5'(occ_r);
          pos_r            <= head_r;
          idx_r            <= '0;
          best_eff_r       <= '0;
          best_r           <= head_r;
          if (stop_r) begin
            rsp_r.status <= apq_pkg::ST_SHUT;
            state_r      <= S_DONE;
          end else if (req_r.func == apq_pkg::FUNC_ENQ) begin
            if (occ_r >= cap) begin
              rsp_r.status <= apq_pkg::ST_FULL;
            end else begin
              tail_r           <= wrap_inc(tail_r, cap);
              occ_r            <= occ_r + 1'b1;
              rsp_r.fill_level <= 5'(occ_r + 1'b1);
            end
            state_r <= S_DONE;
          end else if (occ_r == '0) begin
            rsp_r.status <= apq_pkg::ST_EMPTY;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_WAIT;   // read data lands at the end of this cycle
        S_WAIT: state_r <= aged ? S_DIV : S_CMP;
        S_DIV:  if (div_rsp.done) state_r <= S_CMP;
        S_CMP: begin
          // first entry always wins; later ones on higher rank, or on equal rank with an older stamp
          if (idx_r == '0 || eff > best_eff_r ||
              (eff == best_eff_r && rd_stamp_r < best_stamp_r)) begin
            best_r       <= pos_r;
            best_eff_r   <= eff;
            best_stamp_r <= rd_stamp_r;
          end
          if (idx_r + 1'b1 == occ_r) begin
            state_r <= S_PICK;
          end else begin
            idx_r   <= idx_r + 1'b1;
            pos_r   <= wrap_inc(pos_r, cap);
            state_r <= S_READ;
          end
        end
        S_PICK: begin
          cur_r   <= best_r;
          state_r <= S_SHIFT_RD;
        end
        S_SHIFT_RD: begin
          // first pass: read data holds the picked entry
          if (cur_r == best_r && rsp_r.status == apq_pkg::ST_OK &&
              rsp_r.out_stamp == '0 && idx_r != '1) begin
            rsp_r.out_data     <= rd_data_r;
            rsp_r.out_priority <= rd_prio_r;
            rsp_r.out_source   <= rd_src_r;
            rsp_r.out_stamp    <= rd_stamp_r;
            idx_r              <= '1;   // mark captured
          end
          if (cur_r == head_r) begin
            head_r           <= wrap_inc(head_r, cap);
            occ_r            <= occ_r - 1'b1;
            rsp_r.fill_level <= 5'(occ_r - 1'b1);
            state_r          <= S_DONE;
          end else begin
            state_r <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          // move the entry in front of cur one slot toward the rear
          cur_r   <= wrap_dec(cur_r, cap);
          state_r <= S_SHIFT_RD;
        end
        S_DONE: begin
          if (!ovalid_r) begin
            ovalid_r <= 1'b1;
          end else if (out_ch.ready) begin
            ovalid_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* hdl/apq_div.sv */
// Module: restoring divider, one quotient bit per cycle.
module apq_div (
  input  logic              clk,
  input  logic              rst_n,
  input  apq_pkg::div_req_t req,
  output apq_pkg::div_rsp_t rsp
);
  localparam int unsigned NW = apq_pkg::StampW;
  localparam int unsigned DW = apq_pkg::IvlW;

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW+1:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[NW-1]} - {2'b00, den_r};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[DW+1]) begin
        rem_nxt = {rem_r[DW-1:0], quo_r[NW-1]};
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end else begin
        rem_nxt = trial[DW:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

/* verif/aging_priority_queue_tb.sv */
// Testbench: directed table plus randomized phases for the aging priority queue.
`timescale 1ns / 1ps

module aging_priority_queue_tb;

  localparam int unsigned Depth = 16;

  // Idle styles for the request and result sides.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_t;

  // One row of the directed table: a register write or an item, the latter
  // with a hand-written result where one is plain to see.
  typedef struct {
    row_kind_t                      kind;
    logic [apq_pkg::CfgIdxW-1:0]    reg_idx;
    logic [apq_pkg::CfgW-1:0]       reg_val;
    apq_pkg::req_t                  msg;
    bit                             known;
    apq_pkg::rsp_t                  known_rsp;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [apq_pkg::CfgIdxW-1:0] cfg_index;
  logic [apq_pkg::CfgW-1:0] cfg_data;

  apq_req_if req_ch ();
  apq_rsp_if rsp_ch ();

  aging_priority_queue #(.DEPTH(Depth)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (req_ch.sink),
    .out_ch   (rsp_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Shadow copy of the queue: slot storage, ring pointers and registers.
  logic [apq_pkg::DataW-1:0]  q_payload [Depth];
  logic [apq_pkg::PrioW-1:0]  q_prio    [Depth];
  logic [apq_pkg::SrcW-1:0]   q_src     [Depth];
  logic [apq_pkg::StampW-1:0] q_stamp   [Depth];
  int unsigned q_head, q_tail, q_count;
  logic [15:0] r_interval;
  logic [7:0]  r_cap;
  logic [4:0]  r_slots;
  logic        r_stopped;

  apq_pkg::rsp_t pending_rsp[$];
  row_t          script[$];
  idle_mode_t    idle_mode;
  bit            failed;
  logic [31:0]   wall_clock;

  // Phase plan: aging interval, priority cap, ring length, stop, idling, items.
  logic [15:0] ph_ivl   [9] = '{1000, 0, 1, 65535, 50, 7, 300, 1000, 100};
  logic [7:0]  ph_cap   [9] = '{10, 255, 255, 0, 200, 30, 100, 255, 255};
  logic [4:0]  ph_slots [9] = '{16, 16, 4, 2, 16, 31, 16, 0, 16};
  logic        ph_stop  [9] = '{0, 0, 0, 0, 0, 0, 1, 0, 0};
  idle_mode_t  ph_mode  [9] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                IDLE_SEND, IDLE_BOTH, IDLE_NONE, IDLE_RECV, IDLE_NONE};
  int unsigned ph_items [9] = '{80, 80, 80, 80, 80, 80, 20, 80, 80};

  // Ring length in use: zero acts as one, anything above the depth as the depth.
  function automatic int unsigned ring_len();
    int unsigned c;
    c = 32'(r_slots);
    if (c == 0) c = 1;
    if (c > Depth) c = Depth;
    return c;
  endfunction

  // Effective rank: base priority plus whole aging intervals, capped.
  function automatic longint unsigned aged_rank(int unsigned s, logic [31:0] now);
    longint unsigned eff;
    eff = 64'(q_prio[s]);
    if (now > q_stamp[s] && r_interval != 0)
      eff += 64'((now - q_stamp[s]) / r_interval);
    if (eff > 64'(r_cap)) eff = 64'(r_cap);
    return eff;
  endfunction

  // Apply one item to the shadow queue and return the result it must give.
  function automatic apq_pkg::rsp_t queue_step(apq_pkg::req_t m);
    apq_pkg::rsp_t o;
    int unsigned len, best, pos, cur, prv;
    longint unsigned best_eff, eff;
    logic [31:0] best_stamp;
    o = '0;
    len = ring_len();
    q_head = q_head % len;
    q_tail = q_tail % len;
    if (r_stopped) begin
      o.status = apq_pkg::ST_SHUT;
    end else if (m.func == apq_pkg::FUNC_ENQ) begin
      if (q_count >= len) begin
        o.status = apq_pkg::ST_FULL;
      end else begin
        q_payload[q_tail] = m.in_data;
        q_prio[q_tail] = m.in_priority;
        q_src[q_tail] = m.in_source;
        q_stamp[q_tail] = m.now_time;
        q_tail = (q_tail + 1) % len;
        q_count++;
        o.status = apq_pkg::ST_OK;
      end
    end else if (q_count == 0) begin
      o.status = apq_pkg::ST_EMPTY;
    end else begin
      best = q_head;
      best_eff = aged_rank(best, m.now_time);
      best_stamp = q_stamp[best];
      for (int unsigned i = 1; i < q_count; i++) begin
        pos = (q_head + i) % len;
        eff = aged_rank(pos, m.now_time);
        if (eff > best_eff || (eff == best_eff && q_stamp[pos] < best_stamp)) begin
          best = pos;
          best_eff = eff;
          best_stamp = q_stamp[pos];
        end
      end
      o.status = apq_pkg::ST_OK;
      o.out_data = q_payload[best];
      o.out_priority = q_prio[best];
      o.out_source = q_src[best];
      o.out_stamp = q_stamp[best];
      // Close the gap: everything in front of the pick moves one slot back.
      cur = best;
      while (cur != q_head) begin
        prv = (cur + len - 1) % len;
        q_payload[cur] = q_payload[prv];
        q_prio[cur] = q_prio[prv];
        q_src[cur] = q_src[prv];
        q_stamp[cur] = q_stamp[prv];
        cur = prv;
      end
      q_head = (q_head + 1) % len;
      q_count--;
    end
    o.fill_level = q_count[4:0];
    return o;
  endfunction

  function automatic apq_pkg::req_t make_msg(logic f, logic [31:0] d, logic [7:0] p,
                                             logic [7:0] s, logic [31:0] t);
    apq_pkg::req_t m;
    m.func = f;
    m.in_data = d;
    m.in_priority = p;
    m.in_source = s;
    m.now_time = t;
    return m;
  endfunction

  function automatic void add_cfg(logic [apq_pkg::CfgIdxW-1:0] idx,
                                  logic [apq_pkg::CfgW-1:0] val);
    row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, msg: '0, known: 1'b0, known_rsp: '0};
    script.push_back(r);
  endfunction

  function automatic void add_item(logic f, logic [31:0] d, logic [7:0] p,
                                   logic [7:0] s, logic [31:0] t);
    row_t r;
    r = '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0, msg: make_msg(f, d, p, s, t),
          known: 1'b0, known_rsp: '0};
    script.push_back(r);
  endfunction

  // Item whose result carries no message: only status and fill level matter.
  function automatic void add_known(logic f, logic [31:0] d, logic [7:0] p,
                                    logic [7:0] s, logic [31:0] t,
                                    logic [apq_pkg::StatW-1:0] st, logic [4:0] fill);
    row_t r;
    r = '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0, msg: make_msg(f, d, p, s, t),
          known: 1'b1, known_rsp: '0};
    r.known_rsp.status = st;
    r.known_rsp.fill_level = fill;
    script.push_back(r);
  endfunction

  function automatic bit roll(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit send_gap();
    case (idle_mode)
      IDLE_SEND: return roll(78);
      IDLE_BOTH: return roll(17);
      default:   return 1'b0;
    endcase
  endfunction

  // Hold until every expected result has come back.
  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write a register while the block is idle, and mirror it.
  task automatic write_reg(logic [apq_pkg::CfgIdxW-1:0] idx, logic [apq_pkg::CfgW-1:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      apq_pkg::REG_IVL:  r_interval = val;
      apq_pkg::REG_CAP:  r_cap = val[7:0];
      apq_pkg::REG_SLOT: r_slots = val[4:0];
      apq_pkg::REG_STOP: r_stopped = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one item, hold it until accepted, then queue its expected result.
  task automatic offer_item(apq_pkg::req_t m, bit known, apq_pkg::rsp_t known_rsp);
    apq_pkg::rsp_t predicted;
    while (send_gap()) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= m;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = queue_step(m);
    pending_rsp.push_back(known ? known_rsp : predicted);
    // Drop valid after the accepting edge; the block is busy on the next cycle.
    req_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random item: mostly well-formed traffic that keeps the ring partly full.
  task automatic offer_random();
    apq_pkg::req_t m;
    int unsigned len, enq_pct;
    len = ring_len();
    if (q_count == 0) enq_pct = 90;
    else if (q_count >= len) enq_pct = 30;
    else enq_pct = 55;
    // Advance time by up to a few aging intervals; sometimes jump anywhere.
    case ($urandom_range(99)) inside
      [0:4]:   wall_clock = $urandom;
      [5:7]:   wall_clock = 32'hFFFF_FF00 + $urandom_range(255);
      [8:9]:   wall_clock = $urandom_range(255);
      default: wall_clock += $urandom_range(0, r_interval * 3 + 10);
    endcase
    m.func = roll(enq_pct) ? apq_pkg::FUNC_ENQ : apq_pkg::FUNC_DEQ;
    m.in_data = $urandom;
    m.in_priority = roll(50) ? 8'($urandom_range(15)) : 8'($urandom);
    m.in_source = 8'($urandom);
    m.now_time = wall_clock;
    offer_item(m, 1'b0, '0);
  endtask

  // Empty the ring with dequeues so that its length can change safely.
  task automatic drain_ring();
    while (q_count != 0)
      offer_item(make_msg(apq_pkg::FUNC_DEQ, $urandom, 8'($urandom), 8'($urandom),
                          wall_clock), 1'b0, '0);
  endtask

  // Result side: check each accepted result and pick the next stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_rsp.size() == 0) begin
          $error("result with no item waiting: %p", rsp_ch.payload);
          failed = 1'b1;
        end else begin
          apq_pkg::rsp_t e;
          apq_pkg::rsp_t a;
          e = pending_rsp.pop_front();
          a = rsp_ch.payload;
          if (a.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, a.status);
            failed = 1'b1;
          end
          if (a.out_data !== e.out_data) begin
            $error("out_data: expected %h, got %h", e.out_data, a.out_data);
            failed = 1'b1;
          end
          if (a.out_priority !== e.out_priority) begin
            $error("out_priority: expected %0d, got %0d", e.out_priority, a.out_priority);
            failed = 1'b1;
          end
          if (a.out_source !== e.out_source) begin
            $error("out_source: expected %0d, got %0d", e.out_source, a.out_source);
            failed = 1'b1;
          end
          if (a.out_stamp !== e.out_stamp) begin
            $error("out_stamp: expected %h, got %h", e.out_stamp, a.out_stamp);
            failed = 1'b1;
          end
          if (a.fill_level !== e.fill_level) begin
            $error("fill_level: expected %0d, got %0d", e.fill_level, a.fill_level);
            failed = 1'b1;
          end
        end
      end
      case (idle_mode)
        IDLE_RECV: rsp_ch.ready <= !roll(78);
        IDLE_BOTH: rsp_ch.ready <= !roll(17);
        default:   rsp_ch.ready <= 1'b1;
      endcase
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20_000_000;
    $display("aging_priority_queue regression: fail");
    $finish;
  end

  initial begin
    int unsigned guard;

    failed = 1'b0;
    idle_mode = IDLE_NONE;
    wall_clock = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= apq_pkg::REG_IVL;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.payload <= '0;
    q_head = 0;
    q_tail = 0;
    q_count = 0;
    r_interval = 16'd1000;
    r_cap = 8'd10;
    r_slots = 5'd16;
    r_stopped = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      q_payload[i] = '0;
      q_prio[i] = '0;
      q_src[i] = '0;
      q_stamp[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Reset defaults first: empty, extremes, time wrap.
    add_known(apq_pkg::FUNC_DEQ, 32'h0, 8'h0, 8'h0, 32'h0, apq_pkg::ST_EMPTY, 5'd0);
    add_known(apq_pkg::FUNC_ENQ, 32'h7FFF_FFFF, 8'd255, 8'd0, 32'h0, apq_pkg::ST_OK, 5'd1);
    add_known(apq_pkg::FUNC_ENQ, 32'h8000_0000, 8'd0, 8'd255, 32'hFFFF_FFFF,
              apq_pkg::ST_OK, 5'd2);
    add_known(apq_pkg::FUNC_ENQ, 32'hFFFF_FFFF, 8'd10, 8'hAA, 32'd5000, apq_pkg::ST_OK, 5'd3);
    add_known(apq_pkg::FUNC_ENQ, 32'h0, 8'd3, 8'h55, 32'd100, apq_pkg::ST_OK, 5'd4);
    // Base above the cap, ties on the cap broken by the older stamp.
    add_item(apq_pkg::FUNC_DEQ, 32'h0, 8'h0, 8'h0, 32'hFFFF_FFFF);
    // Time behind every stamp: no boost at all.
    add_item(apq_pkg::FUNC_DEQ, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'h0);
    add_item(apq_pkg::FUNC_DEQ, 32'h0, 8'h0, 8'h0, 32'd7000);
    add_item(apq_pkg::FUNC_DEQ, 32'h0, 8'h0, 8'h0, 32'd7000);
    add_known(apq_pkg::FUNC_DEQ, 32'h0, 8'h0, 8'h0, 32'd7000, apq_pkg::ST_EMPTY, 5'd0);
    // One-slot ring: full on the second enqueue; zero length acts as one.
    add_cfg(apq_pkg::REG_SLOT, 16'd1);
    add_known(apq_pkg::FUNC_ENQ, 32'h1234_5678, 8'd1, 8'd2, 32'd10, apq_pkg::ST_OK, 5'd1);
    add_known(apq_pkg::FUNC_ENQ, 32'h1, 8'd9, 8'd9, 32'd11, apq_pkg::ST_FULL, 5'd1);
    add_item(apq_pkg::FUNC_DEQ, 32'h0, 8'h0, 8'h0, 32'd12);
    add_cfg(apq_pkg::REG_SLOT, 16'd0);
    add_known(apq_pkg::FUNC_ENQ, 32'h2, 8'd2, 8'd2, 32'd20, apq_pkg::ST_OK, 5'd1);
    add_known(apq_pkg::FUNC_ENQ, 32'h3, 8'd3, 8'd3, 32'd21, apq_pkg::ST_FULL, 5'd1);
    // Stopped: both operations rejected, nothing changes.
    add_cfg(apq_pkg::REG_STOP, 16'd1);
    add_known(apq_pkg::FUNC_ENQ, 32'h4, 8'd4, 8'd4, 32'd30, apq_pkg::ST_SHUT, 5'd1);
    add_known(apq_pkg::FUNC_DEQ, 32'h0, 8'h0, 8'h0, 32'd31, apq_pkg::ST_SHUT, 5'd1);
    add_cfg(apq_pkg::REG_STOP, 16'd0);
    add_item(apq_pkg::FUNC_DEQ, 32'h0, 8'h0, 8'h0, 32'd40);
    // Length above the depth acts as the depth; aging off, cap zero.
    add_cfg(apq_pkg::REG_SLOT, 16'hFFFF);
    add_cfg(apq_pkg::REG_IVL, 16'd0);
    add_cfg(apq_pkg::REG_CAP, 16'd0);
    add_known(apq_pkg::FUNC_ENQ, 32'h5, 8'd200, 8'd1, 32'd50, apq_pkg::ST_OK, 5'd1);
    add_known(apq_pkg::FUNC_ENQ, 32'h6, 8'd7, 8'd2, 32'd40, apq_pkg::ST_OK, 5'd2);
    add_item(apq_pkg::FUNC_DEQ, 32'h0, 8'h0, 8'h0, 32'hFFFF_FFFF);
    add_item(apq_pkg::FUNC_DEQ, 32'h0, 8'h0, 8'h0, 32'hFFFF_FFFF);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG)
        write_reg(script[i].reg_idx, script[i].reg_val);
      else
        offer_item(script[i].msg, script[i].known, script[i].known_rsp);
    end

    // Random phases; the ring length changes only once the ring is empty.
    for (int p = 0; p < 9; p++) begin
      idle_mode = ph_mode[p];
      if (r_stopped) write_reg(apq_pkg::REG_STOP, 16'd0);
      if (ph_slots[p] != r_slots) begin
        drain_ring();
        write_reg(apq_pkg::REG_SLOT, apq_pkg::CfgW'(ph_slots[p]));
      end
      write_reg(apq_pkg::REG_IVL, ph_ivl[p]);
      write_reg(apq_pkg::REG_CAP, apq_pkg::CfgW'(ph_cap[p]));
      write_reg(apq_pkg::REG_STOP, apq_pkg::CfgW'(ph_stop[p]));
      for (int n = 0; n < ph_items[p]; n++) begin
        // Pause mid-phase until every result is back.
        if (n == ph_items[p] / 2) begin
          req_ch.valid <= 1'b0;
          wait_drained();
        end
        offer_random();
      end
    end
    req_ch.valid <= 1'b0;

    guard = 0;
    while (pending_rsp.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_rsp.size() != 0) begin
      $error("%0d results never arrived", pending_rsp.size());
      failed = 1'b1;
    end
    repeat (50) @(posedge clk);
    if (!failed)
      $display("aging_priority_queue regression: pass");
    else
      $display("aging_priority_queue regression: fail");
    $finish;
  end

endmodule
